// ----- src/wildcard_pattern_matcher_macros.svh -----
// Assertion macros shared by the wildcard matcher modules
`ifndef WILDCARD_PATTERN_MATCHER_MACROS_SVH
`define WILDCARD_PATTERN_MATCHER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define WPM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("wpm check failed: same-cycle rule");

// Next-cycle implication, sampled on clk, off while rst_n is low
`define WPM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("wpm check failed: next-cycle rule");

`endif

// ----- src/wpm_pkg.sv -----
// Shared types and constants for the wildcard pattern matcher
package wpm_pkg;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_PATH   = 2'd2,
    OP_END    = 2'd3
  } op_t;

  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_QUEST = 8'h3F;
  localparam logic [7:0] CH_DOT   = 8'h2E;

  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] character;
  } in_item_t;

  typedef struct packed {
    logic matched;
    logic pattern_overflow;
  } out_item_t;

  // Decoded item as it travels from front to back
  typedef struct packed {
    op_t        op;
    logic [7:0] character;
    logic       is_dot;
  } cmd_t;

endpackage

// ----- src/wpm_front.sv -----
// Front end: accepts input items, decodes them and hands them to the queue
module wpm_front import wpm_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  output logic     cmd_valid,
  input  logic     cmd_ready,
  output cmd_t     cmd_data
);

  logic hold_valid_r, hold_valid_nxt;
  cmd_t hold_cmd_r;
  cmd_t decoded;

  assign in_ready  = !hold_valid_r || cmd_ready;
  assign cmd_valid = hold_valid_r;
  assign cmd_data  = hold_cmd_r;

  always_comb begin
    decoded.op        = op_t'(in_data.operation);
    decoded.character = in_data.character;
    decoded.is_dot    = (in_data.character == CH_DOT);
  end

  always_comb begin
    hold_valid_nxt = (in_valid && in_ready) || (hold_valid_r && !cmd_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else begin
      hold_valid_r <= hold_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_cmd_r <= decoded;
    end
  end

endmodule

// ----- src/wpm_queue.sv -----
// Short FIFO of decoded items between front and back
`include "wildcard_pattern_matcher_macros.svh"
module wpm_queue import wpm_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic enq_valid,
  output logic enq_ready,
  input  cmd_t enq_data,
  output logic deq_valid,
  input  logic deq_ready,
  output cmd_t deq_data
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

  cmd_t             mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             push, pop;

  assign enq_ready = (count_r != FULL_CNT);
  assign deq_valid = (count_r != '0);
  assign deq_data  = mem_r[rd_ptr_r];
  assign push      = enq_valid && enq_ready;
  assign pop       = deq_valid && deq_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= enq_data;
    end
  end

  `WPM_ASSERT_NOW(a_count_bound, 1'b1, count_r <= FULL_CNT)
  `WPM_ASSERT_NOW(a_empty_ptrs, count_r == '0, wr_ptr_r == rd_ptr_r)
  `WPM_ASSERT_NEXT(a_push_grows, push && !pop, count_r == $past(count_r) + 1'b1)

endmodule

// ----- src/wpm_back.sv -----
// Back end: pattern store, live-position vector and result register
`include "wildcard_pattern_matcher_macros.svh"
module wpm_back import wpm_pkg::*; #(
  parameter int MAX_PATTERN = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cmd_valid,
  output logic      cmd_ready,
  input  cmd_t      cmd_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int N     = MAX_PATTERN + 1;
  localparam int STEPS = (N > 1) ? $clog2(N) : 1;
  localparam logic [N-1:0] RESTART = N'(1);

  logic [7:0]             store_r [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] len_therm_r, len_therm_nxt;
  logic [N-1:0]           active_r, active_nxt;
  logic                   overflow_r, overflow_nxt;
  logic                   out_valid_r, out_valid_nxt;
  out_item_t              out_data_r, out_data_nxt;

  logic [MAX_PATTERN-1:0] star_vec, match_vec, wr_sel;
  logic [N-1:0]           closed, allowed, at_len, advanced;
  logic                   full, hit, pop;

  assign full      = len_therm_r[MAX_PATTERN-1];
  assign cmd_ready = (cmd_data.op != OP_END) || !out_valid_r || out_ready;
  assign pop       = cmd_valid && cmd_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // allowed: positions 0..len; at_len: position len alone
  assign allowed = {len_therm_r, 1'b1};
  assign at_len  = allowed & ~{1'b0, len_therm_r};
  assign wr_sel  = at_len[MAX_PATTERN-1:0];

  always_comb begin
    for (int p = 0; p < MAX_PATTERN; p++) begin
      star_vec[p]  = len_therm_r[p] && (store_r[p] == CH_STAR);
      match_vec[p] = len_therm_r[p] && (store_r[p] != CH_STAR) &&
                     ((store_r[p] == cmd_data.character) ||
                      ((store_r[p] == CH_QUEST) && !cmd_data.is_dot));
    end
  end

  // Star closure as a parallel prefix: a live star makes the next position live
  always_comb begin
    logic [N-1:0] gen;
    logic [N-1:0] prop;
    gen  = active_r;
    prop = {star_vec, 1'b0};
    for (int s = 0; s < STEPS; s++) begin
      gen  = gen | (prop & (gen << (1 << s)));
      prop = prop & (prop << (1 << s));
    end
    closed = gen;
  end

  assign advanced = {1'b0, closed[MAX_PATTERN-1:0] & star_vec} |
                    {closed[MAX_PATTERN-1:0] & match_vec, 1'b0};
  assign hit      = |(closed & at_len);

  always_comb begin
    len_therm_nxt = len_therm_r;
    active_nxt    = active_r;
    overflow_nxt  = overflow_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    if (pop) begin
      unique case (cmd_data.op)
        OP_CLEAR: begin
          len_therm_nxt = '0;
          overflow_nxt  = 1'b0;
          active_nxt    = RESTART;
        end
        OP_APPEND: begin
          if (full) begin
            overflow_nxt = 1'b1;
          end else begin
            len_therm_nxt = len_therm_r | wr_sel;
          end
          active_nxt = RESTART;
        end
        OP_PATH: begin
          active_nxt = advanced;
        end
        OP_END: begin
          out_valid_nxt                 = 1'b1;
          out_data_nxt.matched          = hit && !overflow_r;
          out_data_nxt.pattern_overflow = overflow_r;
          active_nxt                    = RESTART;
        end
        default: begin
          active_nxt = active_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_therm_r <= '0;
      active_r    <= RESTART;
      overflow_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      len_therm_r <= len_therm_nxt;
      active_r    <= active_nxt;
      overflow_r  <= overflow_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  // Each cell loads only when it is the next free slot
  always_ff @(posedge clk) begin
    for (int p = 0; p < MAX_PATTERN; p++) begin
      if (pop && (cmd_data.op == OP_APPEND) && wr_sel[p]) begin
        store_r[p] <= cmd_data.character;
      end
    end
  end

  `WPM_ASSERT_NOW(a_active_in_range, 1'b1, (active_r & ~allowed) == '0)
  `WPM_ASSERT_NOW(a_overflow_full, overflow_r, full)
  `WPM_ASSERT_NEXT(a_end_gives_result, pop && (cmd_data.op == OP_END), out_valid_r)

endmodule

// ----- src/wildcard_pattern_matcher.sv -----
// Top level of the wildcard pattern matcher: front, queue and back
//
//  channel | direction | handshake            | payload
//  in_     | input     | in_valid / in_ready   | in_data (operation, character)
//  out_    | output    | out_valid / out_ready | out_data (matched, pattern_overflow)
//
// One item per cycle sustained while out_ready does not hold back an end-of-path item; an end-of-path
// result passes in turn the front register (loaded on accept), a queue entry and the output register.
// The star closure and position advance are one parallel prefix per cycle in the back.
// Reset is synchronous on rst_n low: empty pattern, position zero live, no overflow.
// A stalled out_ready holds end-of-path items only; the queue lets input keep flowing until it is full.
module wildcard_pattern_matcher import wpm_pkg::*; #(
  parameter int MAX_PATTERN = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic f_valid, f_ready;
  cmd_t f_cmd;
  logic q_valid, q_ready;
  cmd_t q_cmd;

  wpm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cmd_valid (f_valid),
    .cmd_ready (f_ready),
    .cmd_data  (f_cmd)
  );

  wpm_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .enq_valid (f_valid),
    .enq_ready (f_ready),
    .enq_data  (f_cmd),
    .deq_valid (q_valid),
    .deq_ready (q_ready),
    .deq_data  (q_cmd)
  );

  wpm_back #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (q_valid),
    .cmd_ready (q_ready),
    .cmd_data  (q_cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
